/* hdl/bpss_pkg.sv */
// Shared types, codes and the phase table of the stimulation pulse sequencer.
// No dependencies; used by the sequencer top level and its port checker.
package bpss_pkg;

    localparam int AMP_W       = 17;
    localparam int GAIN_W      = 16;
    localparam int OFFS_W      = 21;
    localparam int DAC_W       = 32;
    localparam int PHASE_W     = 4;
    localparam int IDX_W       = 4;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    localparam logic [PHASE_W-1:0] PHASE_FIRST    = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_TERMINAL = 4'd11;

    // request kinds
    localparam logic REQ_RESET = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // timer modes
    localparam logic [1:0] TMR_NONE   = 2'd0;
    localparam logic [1:0] TMR_START  = 2'd1;
    localparam logic [1:0] TMR_RELOAD = 2'd2;

    // mux codes
    localparam logic [2:0] MUX_A_POS = 3'd0;
    localparam logic [2:0] MUX_A_INV = 3'd1;
    localparam logic [2:0] MUX_B_POS = 3'd2;
    localparam logic [2:0] MUX_B_INV = 3'd3;
    localparam logic [2:0] MUX_OPEN  = 3'd4;

    // charge and pin controls: unchanged, off/low, on/high
    localparam logic [1:0] CTL_KEEP = 2'd0;
    localparam logic [1:0] CTL_OFF  = 2'd1;
    localparam logic [1:0] CTL_ON   = 2'd2;

    localparam logic [IDX_W-1:0] IDX_START = 4'd0;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_STIM_ENABLE = 2'd0;
    localparam logic [1:0] REG_SHUTDOWN    = 2'd1;
    localparam logic [1:0] REG_DAC_GAIN    = 2'd2;
    localparam logic [1:0] REG_DAC_OFFSET  = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd3000;

    typedef enum logic [1:0] {
        DAC_SRC_NONE = 2'd0,
        DAC_SRC_ZERO = 2'd1,
        DAC_SRC_A    = 2'd2,
        DAC_SRC_B    = 2'd3
    } dac_src_t;

    typedef struct packed {
        logic             mux_write;
        logic [2:0]       mux_code;
        dac_src_t         dac_src;
        logic [1:0]       vccs;
        logic [1:0]       hv;
        logic [1:0]       aux;
        logic [IDX_W-1:0] idx;
    } phase_row_t;

    // Result item, last field in the lowest bits of tdata.
    typedef struct packed {
        logic [1:0]         pad;
        logic [PHASE_W-1:0] phase;
        logic [1:0]         aux_pin;
        logic [1:0]         hv_charge;
        logic [1:0]         vccs_charge;
        logic [DAC_W-1:0]   dac_value;
        logic               dac_write;
        logic [2:0]         mux_code;
        logic               mux_write;
        logic [IDX_W-1:0]   interval_index;
        logic [1:0]         timer_mode;
        logic               acted;
    } out_item_t;

    function automatic phase_row_t phase_row(input logic [PHASE_W-1:0] ph);
        phase_row_t r;
        r = '{mux_write: 1'b1, mux_code: MUX_A_POS, dac_src: DAC_SRC_ZERO,
              vccs: CTL_KEEP, hv: CTL_KEEP, aux: CTL_KEEP, idx: '0};
        unique case (ph)
            4'd0:
            begin
                r.vccs = CTL_OFF;
                r.idx  = 4'd1;
            end
            4'd1:
            begin
                r.dac_src = DAC_SRC_A;
                r.idx     = 4'd2;
            end
            4'd2:
            begin
                r.mux_code = MUX_A_INV;
                r.idx      = 4'd3;
            end
            4'd3:
            begin
                r.mux_code = MUX_A_INV;
                r.dac_src  = DAC_SRC_A;
                r.idx      = 4'd4;
            end
            4'd4:
            begin
                r.mux_code = MUX_B_POS;
                r.idx      = 4'd5;
            end
            4'd5:
            begin
                r.mux_code = MUX_B_POS;
                r.dac_src  = DAC_SRC_B;
                r.idx      = 4'd6;
            end
            4'd6:
            begin
                r.mux_code = MUX_B_INV;
                r.idx      = 4'd7;
            end
            4'd7:
            begin
                r.mux_code = MUX_B_INV;
                r.dac_src  = DAC_SRC_B;
                r.idx      = 4'd8;
            end
            4'd8:
            begin
                r.mux_code = MUX_OPEN;
                r.idx      = 4'd9;
            end
            4'd9:
            begin
                r = '{mux_write: 1'b0, mux_code: MUX_A_POS, dac_src: DAC_SRC_NONE,
                      vccs: CTL_ON, hv: CTL_ON, aux: CTL_ON, idx: 4'd10};
            end
            4'd10:
            begin
                r = '{mux_write: 1'b0, mux_code: MUX_A_POS, dac_src: DAC_SRC_NONE,
                      vccs: CTL_OFF, hv: CTL_OFF, aux: CTL_OFF, idx: 4'd10};
            end
            default:
            begin
                r = '{mux_write: 1'b0, mux_code: MUX_A_POS, dac_src: DAC_SRC_NONE,
                      vccs: CTL_KEEP, hv: CTL_KEEP, aux: CTL_KEEP, idx: '0};
            end
        endcase
        return r;
    endfunction

endpackage

/* hdl/biphasic_stim_pulse_sequencer.sv */
// Biphasic two-channel stimulation pulse sequencer, top level.
// Depends on bpss_pkg for codes, the phase table and the result layout.
// A request is registered in the phase decode register and then in the DAC result
// register before its result is valid on m_axis.
// Throughput: one request per cycle while m_axis is not stalled; the phase decode
// register and the DAC multiply-offset stage run overlapped.
// Reset: phase returns to 0, registers take their reset values, both stages empty.
module biphasic_stim_pulse_sequencer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bpss_pkg::PADDR_W-1:0]       paddr,
    input  logic [bpss_pkg::PDATA_W-1:0]       pwdata,
    output logic [bpss_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // amp_a [16:0], amp_b [33:17], zero fill [39:34]
    input  logic [bpss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type [0]
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // acted [0], timer_mode [2:1], interval_index [6:3], mux_write [7],
    // mux_code [10:8], dac_write [11], dac_value [43:12], vccs_charge [45:44],
    // hv_charge [47:46], aux_pin [49:48], phase [53:50], zero fill [55:54]
    output logic [bpss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int AMP_W  = bpss_pkg::AMP_W;
    localparam int GAIN_W = bpss_pkg::GAIN_W;
    localparam int OFFS_W = bpss_pkg::OFFS_W;
    localparam int PROD_W = AMP_W + GAIN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DAC_W  = bpss_pkg::DAC_W;

    // configuration registers
    logic                 stim_enable_reg;
    logic                 shutdown_reg;
    logic [GAIN_W-1:0]    dac_gain_reg;
    logic [OFFS_W-1:0]    dac_offset_reg;
    logic                 cfg_write;

    // pipeline
    logic [bpss_pkg::PHASE_W-1:0] phase_reg;
    logic                         s1_valid_reg;
    bpss_pkg::out_item_t          s1_item_reg;
    bpss_pkg::out_item_t          s1_item_next;
    logic [AMP_W-1:0]             s1_amp_reg;
    logic [AMP_W-1:0]             s1_amp_next;
    logic                         m_valid_reg;
    bpss_pkg::out_item_t          m_item_reg;
    bpss_pkg::out_item_t          m_item_next;

    logic                 out_ready;
    logic                 in_accept;
    logic                 s1_advance;
    logic                 req_type;
    logic [AMP_W-1:0]     amp_a;
    logic [AMP_W-1:0]     amp_b;
    bpss_pkg::phase_row_t row;

    logic [PROD_W-1:0]    product;
    logic [OFFS_W-1:0]    offset_mag;
    logic [SUM_W-1:0]     adjusted;
    logic [DAC_W-1:0]     dac_sat;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stim_enable_reg <= 1'b0;
            shutdown_reg    <= 1'b0;
            dac_gain_reg    <= bpss_pkg::GAIN_RESET;
            dac_offset_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                bpss_pkg::REG_STIM_ENABLE: stim_enable_reg <= pwdata[0];
                bpss_pkg::REG_SHUTDOWN:    shutdown_reg    <= pwdata[0];
                bpss_pkg::REG_DAC_GAIN:    dac_gain_reg    <= pwdata[GAIN_W-1:0];
                bpss_pkg::REG_DAC_OFFSET:  dac_offset_reg  <= pwdata[OFFS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bpss_pkg::REG_STIM_ENABLE: prdata = {31'd0, stim_enable_reg};
            bpss_pkg::REG_SHUTDOWN:    prdata = {31'd0, shutdown_reg};
            bpss_pkg::REG_DAC_GAIN:    prdata = {16'd0, dac_gain_reg};
            bpss_pkg::REG_DAC_OFFSET:
                prdata = {{(bpss_pkg::PDATA_W-OFFS_W){dac_offset_reg[OFFS_W-1]}},
                          dac_offset_reg};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s1_advance    = s1_valid_reg && out_ready;

    // ---------------- stage 1: phase step ----------------
    assign req_type = s_axis_tuser[0];
    assign amp_a    = s_axis_tdata[AMP_W-1:0];
    assign amp_b    = s_axis_tdata[2*AMP_W-1:AMP_W];
    assign row      = bpss_pkg::phase_row(phase_reg);

    always_comb
    begin
        s1_item_next       = '0;
        s1_item_next.phase = phase_reg;
        s1_amp_next        = '0;
        priority if (shutdown_reg)
        begin
            // frozen: report the phase, drive nothing
        end
        else if (req_type == bpss_pkg::REQ_RESET)
        begin
            s1_item_next.acted          = 1'b1;
            s1_item_next.timer_mode     = bpss_pkg::TMR_START;
            s1_item_next.interval_index = bpss_pkg::IDX_START;
            s1_item_next.phase          = bpss_pkg::PHASE_FIRST;
        end
        else if (phase_reg >= bpss_pkg::PHASE_TERMINAL)
        begin
            // terminal phase: hold until a reset request
        end
        else
        begin
            s1_item_next.acted          = 1'b1;
            s1_item_next.timer_mode     = bpss_pkg::TMR_RELOAD;
            s1_item_next.interval_index = row.idx;
            s1_item_next.mux_write      = row.mux_write;
            s1_item_next.mux_code       = row.mux_code;
            s1_item_next.dac_write      = (row.dac_src != bpss_pkg::DAC_SRC_NONE)
                                          && stim_enable_reg;
            s1_item_next.vccs_charge    = row.vccs;
            s1_item_next.hv_charge      = row.hv;
            s1_item_next.aux_pin        = row.aux;
            s1_item_next.phase          = phase_reg + 4'd1;
            if (row.dac_src == bpss_pkg::DAC_SRC_A)
            begin
                s1_amp_next = amp_a;
            end
            else if (row.dac_src == bpss_pkg::DAC_SRC_B)
            begin
                s1_amp_next = amp_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= bpss_pkg::PHASE_FIRST;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg    <= s1_item_next.phase;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= s1_item_next;
            s1_amp_reg  <= s1_amp_next;
        end
    end

    // ---------------- stage 2: DAC code ----------------
    assign product    = PROD_W'(s1_amp_reg) * PROD_W'(dac_gain_reg);
    assign offset_mag = OFFS_W'(0) - dac_offset_reg;

    always_comb
    begin
        priority if (dac_offset_reg[OFFS_W-1])
        begin
            // negative offset adds its magnitude
            adjusted = SUM_W'(product) + SUM_W'(offset_mag);
        end
        else if (SUM_W'(dac_offset_reg) < SUM_W'(product))
        begin
            adjusted = SUM_W'(product) - SUM_W'(dac_offset_reg);
        end
        else
        begin
            adjusted = SUM_W'(product);
        end
    end

    assign dac_sat = (adjusted[SUM_W-1:DAC_W] != '0) ? '1 : adjusted[DAC_W-1:0];

    always_comb
    begin
        m_item_next           = s1_item_reg;
        m_item_next.dac_value = s1_item_reg.dac_write ? dac_sat : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_item_reg;

endmodule

/* hdl/bpss_checker.sv */
// Port-level checks on the stimulation pulse sequencer result stream.
// Depends on bpss_pkg; bound to biphasic_stim_pulse_sequencer below.
module bpss_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bpss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    bpss_pkg::out_item_t item;

    assign item = bpss_pkg::out_item_t'(m_axis_tdata);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an idle event drives no control
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !item.acted |->
            item.timer_mode == bpss_pkg::TMR_NONE && !item.mux_write &&
            !item.dac_write && item.vccs_charge == bpss_pkg::CTL_KEEP)
        else $error("control driven on an event that did not act");

    // a timer start only comes from a reset request
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && item.timer_mode == bpss_pkg::TMR_START |->
            item.phase == bpss_pkg::PHASE_FIRST &&
            item.interval_index == bpss_pkg::IDX_START && !item.mux_write &&
            !item.dac_write)
        else $error("timer start not tied to a sequencer reset");

    // an unwritten DAC reads zero
    a_dac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !item.dac_write |-> item.dac_value == '0)
        else $error("DAC value set without a DAC write");

    // a reload always advances out of the first phase
    a_reload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && item.timer_mode == bpss_pkg::TMR_RELOAD |->
            item.phase != bpss_pkg::PHASE_FIRST && item.acted)
        else $error("reload reported without a phase advance");

endmodule

bind biphasic_stim_pulse_sequencer bpss_checker u_bpss_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the biphasic stimulation pulse sequencer: APB register setup,
// stream requests in, predicted results compared field by field. Depends on bpss_pkg.
module tb_top;

    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    localparam int AMP_W       = bpss_pkg::AMP_W;
    localparam int GAIN_W      = bpss_pkg::GAIN_W;
    localparam int OFFS_W      = bpss_pkg::OFFS_W;
    localparam int DAC_W       = bpss_pkg::DAC_W;
    localparam int PHASE_W     = bpss_pkg::PHASE_W;
    localparam int IDX_W       = bpss_pkg::IDX_W;
    localparam int PADDR_W     = bpss_pkg::PADDR_W;
    localparam int PDATA_W     = bpss_pkg::PDATA_W;
    localparam int IN_TDATA_W  = bpss_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = bpss_pkg::OUT_TDATA_W;

    typedef struct packed {
        logic             kind;
        logic [AMP_W-1:0] amp_a;
        logic [AMP_W-1:0] amp_b;
    } stim_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // amp_a [16:0], amp_b [33:17], zero fill [39:34]
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    // req_type [0]
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // acted [0], timer_mode [2:1], interval_index [6:3], mux_write [7], mux_code [10:8],
    // dac_write [11], dac_value [43:12], vccs_charge [45:44], hv_charge [47:46],
    // aux_pin [49:48], phase [53:50], zero fill [55:54]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    biphasic_stim_pulse_sequencer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state and register copies
    logic [PHASE_W-1:0] seq_phase = bpss_pkg::PHASE_FIRST;
    logic               cfg_stim = 1'b0;
    logic               cfg_shutdown = 1'b0;
    logic [GAIN_W-1:0]  cfg_gain = bpss_pkg::GAIN_RESET;
    logic [OFFS_W-1:0]  cfg_offset = '0;

    stim_req_t pending_reqs[$];
    bpss_pkg::out_item_t expected_results[$];
    stim_req_t req_on_bus;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int errors = 0;
    int reqs_sent = 0;
    int reqs_issued = 0;
    int results_checked = 0;
    int settings_used = 0;
    int stuck_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [DAC_W-1:0] scale_amp(input logic [AMP_W-1:0] amp);
        logic [63:0] prod;
        logic [63:0] amp64;
        logic [63:0] gain64;
        logic [63:0] off64;
        amp64 = 64'(amp);
        gain64 = 64'(cfg_gain);
        off64 = 64'(cfg_offset);
        prod = amp64 * gain64;
        if (cfg_offset[OFFS_W-1])
            prod = prod + ((64'd1 << OFFS_W) - off64);
        else if (off64 < prod)
            prod = prod - off64;
        if (prod > 64'hFFFF_FFFF)
            return '1;
        return prod[DAC_W-1:0];
    endfunction

    // one timer event: returns the expected result and resets, advances or holds the phase
    function automatic bpss_pkg::out_item_t step_sequencer(input stim_req_t r);
        bpss_pkg::out_item_t o;
        logic mux_en;
        logic [2:0] mux;
        bpss_pkg::dac_src_t src;
        logic [1:0] vccs;
        logic [1:0] hv;
        logic [1:0] aux;
        logic [IDX_W-1:0] idx;
        o = '0;
        if (cfg_shutdown)
        begin
            o.phase = seq_phase;
            return o;
        end
        if (r.kind == bpss_pkg::REQ_RESET)
        begin
            seq_phase = bpss_pkg::PHASE_FIRST;
            o.acted = 1'b1;
            o.timer_mode = bpss_pkg::TMR_START;
            o.interval_index = bpss_pkg::IDX_START;
            o.phase = bpss_pkg::PHASE_FIRST;
            return o;
        end
        if (seq_phase >= bpss_pkg::PHASE_TERMINAL)
        begin
            o.phase = seq_phase;
            return o;
        end
        mux_en = 1'b1;
        mux = bpss_pkg::MUX_A_POS;
        src = bpss_pkg::DAC_SRC_ZERO;
        vccs = bpss_pkg::CTL_KEEP;
        hv = bpss_pkg::CTL_KEEP;
        aux = bpss_pkg::CTL_KEEP;
        idx = seq_phase + 4'd1;
        case (seq_phase)
            4'd0: vccs = bpss_pkg::CTL_OFF;
            4'd1: src = bpss_pkg::DAC_SRC_A;
            4'd2: mux = bpss_pkg::MUX_A_INV;
            4'd3:
            begin
                mux = bpss_pkg::MUX_A_INV;
                src = bpss_pkg::DAC_SRC_A;
            end
            4'd4: mux = bpss_pkg::MUX_B_POS;
            4'd5:
            begin
                mux = bpss_pkg::MUX_B_POS;
                src = bpss_pkg::DAC_SRC_B;
            end
            4'd6: mux = bpss_pkg::MUX_B_INV;
            4'd7:
            begin
                mux = bpss_pkg::MUX_B_INV;
                src = bpss_pkg::DAC_SRC_B;
            end
            4'd8: mux = bpss_pkg::MUX_OPEN;
            4'd9:
            begin
                mux_en = 1'b0;
                src = bpss_pkg::DAC_SRC_NONE;
                vccs = bpss_pkg::CTL_ON;
                hv = bpss_pkg::CTL_ON;
                aux = bpss_pkg::CTL_ON;
            end
            default:
            begin
                // residual phase: everything off, same interval as charge
                mux_en = 1'b0;
                src = bpss_pkg::DAC_SRC_NONE;
                vccs = bpss_pkg::CTL_OFF;
                hv = bpss_pkg::CTL_OFF;
                aux = bpss_pkg::CTL_OFF;
                idx = 4'd10;
            end
        endcase
        o.acted = 1'b1;
        o.timer_mode = bpss_pkg::TMR_RELOAD;
        o.interval_index = idx;
        o.mux_write = mux_en;
        o.mux_code = mux_en ? mux : bpss_pkg::MUX_A_POS;
        if (src != bpss_pkg::DAC_SRC_NONE && cfg_stim)
        begin
            o.dac_write = 1'b1;
            case (src)
                bpss_pkg::DAC_SRC_A: o.dac_value = scale_amp(r.amp_a);
                bpss_pkg::DAC_SRC_B: o.dac_value = scale_amp(r.amp_b);
                default: o.dac_value = scale_amp('0);
            endcase
        end
        o.vccs_charge = vccs;
        o.hv_charge = hv;
        o.aux_pin = aux;
        seq_phase = seq_phase + 4'd1;
        o.phase = seq_phase;
        return o;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(step_sequencer(req_on_bus));
                reqs_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    req_on_bus = pending_reqs.pop_front();
                    reqs_issued++;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= req_on_bus.kind;
                    s_axis_tdata <= {{(IN_TDATA_W - 2 * AMP_W){1'b0}},
                                     req_on_bus.amp_b, req_on_bus.amp_a};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    // result monitor, receiver stalls and watchdog
    always @(posedge clk)
    begin
        bpss_pkg::out_item_t got;
        bpss_pkg::out_item_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result 0x%0h, expected none", $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("acted", 64'(want.acted), 64'(got.acted));
                    check_field("timer_mode", 64'(want.timer_mode), 64'(got.timer_mode));
                    check_field("interval_index", 64'(want.interval_index),
                                64'(got.interval_index));
                    check_field("mux_write", 64'(want.mux_write), 64'(got.mux_write));
                    check_field("mux_code", 64'(want.mux_code), 64'(got.mux_code));
                    check_field("dac_write", 64'(want.dac_write), 64'(got.dac_write));
                    check_field("dac_value", 64'(want.dac_value), 64'(got.dac_value));
                    check_field("vccs_charge", 64'(want.vccs_charge), 64'(got.vccs_charge));
                    check_field("hv_charge", 64'(want.hv_charge), 64'(got.hv_charge));
                    check_field("aux_pin", 64'(want.aux_pin), 64'(got.aux_pin));
                    check_field("phase", 64'(want.phase), 64'(got.phase));
                    check_field("zero fill", 64'(want.pad), 64'(got.pad));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, stuck_cycles, expected_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bpss_pkg::REG_STIM_ENABLE: cfg_stim = value[0];
            bpss_pkg::REG_SHUTDOWN: cfg_shutdown = value[0];
            bpss_pkg::REG_DAC_GAIN: cfg_gain = value[GAIN_W-1:0];
            default: cfg_offset = value[OFFS_W-1:0];
        endcase
    endtask

    // every request handed to the bus must come back before this returns
    task automatic wait_all_results();
        while (pending_reqs.size() != 0 || reqs_issued != results_checked)
            @(posedge clk);
    endtask

    task automatic push_req(input logic kind, input int a, input int b);
        stim_req_t r;
        r.kind = kind;
        r.amp_a = AMP_W'(a);
        r.amp_b = AMP_W'(b);
        pending_reqs.push_back(r);
    endtask

    function automatic int rand_amp();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 100000;
            2, 3: return $urandom_range(0, 400);
            default: return $urandom_range(0, 100000);
        endcase
    endfunction

    // mostly full trains from a reset, some loose events in between
    task automatic add_random_trains(input int count);
        int added;
        int k;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                push_req(bpss_pkg::REQ_RESET, rand_amp(), rand_amp());
                k = $urandom_range(9, 13);
                repeat (k) push_req(bpss_pkg::REQ_NEXT, rand_amp(), rand_amp());
                added += k + 1;
            end
            else
            begin
                k = $urandom_range(1, 4);
                repeat (k) push_req(1'($urandom_range(0, 1)), rand_amp(), rand_amp());
                added += k;
            end
        end
    endtask

    task automatic pick_settings(input int round);
        logic [PDATA_W-1:0] gain;
        logic [OFFS_W-1:0] offset;
        case ($urandom_range(0, 3))
            0: gain = 65535;
            1: gain = $urandom_range(1, 8000);
            2: gain = $urandom_range(0, 65535);
            default: gain = {{(PDATA_W - GAIN_W){1'b0}}, bpss_pkg::GAIN_RESET};
        endcase
        case ($urandom_range(0, 4))
            0: offset = 21'h100000;
            1: offset = 21'h0FFFFF;
            2: offset = OFFS_W'($urandom_range(0, 1200000));
            3: offset = '0;
            default: offset = OFFS_W'($urandom_range(0, 21'h1FFFFF));
        endcase
        write_reg(bpss_pkg::REG_STIM_ENABLE, (round == 5) ? 32'd0 : 32'd1);
        write_reg(bpss_pkg::REG_SHUTDOWN, (round == 6) ? 32'd1 : 32'd0);
        write_reg(bpss_pkg::REG_DAC_GAIN, gain);
        write_reg(bpss_pkg::REG_DAC_OFFSET, {{(PDATA_W - OFFS_W){1'b0}}, offset});
        settings_used++;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // full train at maximum gain and most negative offset, then the terminal phase
        write_reg(bpss_pkg::REG_STIM_ENABLE, 32'd1);
        write_reg(bpss_pkg::REG_DAC_GAIN, 32'd65535);
        write_reg(bpss_pkg::REG_DAC_OFFSET, 32'h0010_0000);
        settings_used++;
        push_req(bpss_pkg::REQ_RESET, 100000, 100000);
        repeat (11) push_req(bpss_pkg::REQ_NEXT, 100000, 0);
        repeat (2) push_req(bpss_pkg::REQ_NEXT, 0, 100000);
        wait_all_results();

        // zero gain against the largest positive offset
        write_reg(bpss_pkg::REG_DAC_GAIN, 32'd0);
        write_reg(bpss_pkg::REG_DAC_OFFSET, 32'h000F_FFFF);
        settings_used++;
        push_req(bpss_pkg::REQ_RESET, 1, 100000);
        repeat (5) push_req(bpss_pkg::REQ_NEXT, 1, 100000);
        wait_all_results();

        // frozen sequencer ignores both kinds
        write_reg(bpss_pkg::REG_SHUTDOWN, 32'd1);
        settings_used++;
        push_req(bpss_pkg::REQ_NEXT, 100000, 100000);
        push_req(bpss_pkg::REQ_RESET, 0, 0);
        wait_all_results();

        // stimulation off: mux and timer still run
        write_reg(bpss_pkg::REG_SHUTDOWN, 32'd0);
        write_reg(bpss_pkg::REG_STIM_ENABLE, 32'd0);
        settings_used++;
        repeat (3) push_req(bpss_pkg::REQ_NEXT, 100000, 100000);
        wait_all_results();

        for (int round = 0; round < 8; round++)
        begin
            pick_settings(round);
            case (round % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 56;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 56;
                end
                default:
                begin
                    sender_idle_pct = 11;
                    receiver_stall_pct = 11;
                end
            endcase
            if (round == 6)
            begin
                add_random_trains(40);
            end
            else if (round == 2)
            begin
                // hold requests back until the pipe has fully drained, then resume
                add_random_trains(80);
                wait_all_results();
                add_random_trains(80);
            end
            else
            begin
                add_random_trains(160);
            end
            wait_all_results();
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests under %0d register settings and four idle mixes.",
                 reqs_sent, settings_used);
        $display("Checked %0d results, %0d field mismatches, %0d results outstanding.",
                 results_checked, errors, expected_results.size());
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
